// ===== hdl/jtl_pkg.sv =====
// Shared types and constants for the JSON token lexer.
// Used by jtl_front, jtl_queue, jtl_back and json_token_lexer_unit.
package jtl_pkg;

  localparam int LINE_WIDTH = 24;
  localparam int LINE_OUT_W = 24;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TEND = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_EOI  = 2'd3
  } kind_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_INVALID = 2'd0,
    ERR_NEWLINE = 2'd1,
    ERR_SYNTAX  = 2'd2,
    ERR_EOF_ESC = 2'd3
  } err_t;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [15:0] UTF_3BYTE_MIN = 16'h0800;
  localparam logic [15:0] UTF_2BYTE_MIN = 16'h0080;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    err_t       err;
  } result_t;

  // Up to three results caused by one input beat, all on the same line
  typedef struct packed {
    logic [1:0]            cnt;
    result_t [2:0]         res;
    logic [LINE_OUT_W-1:0] line;
  } bundle_t;

endpackage

// ===== hdl/json_token_lexer_unit.sv =====
// JSON token lexer: text bytes in, token/error/end-of-input beats out.
// Each input beat's results pass through a registered 4-deep bundle queue.
// Throughput: one input beat per cycle while the queue is not full; one result
// beat per cycle while m_tready is high, so a beat causing two or three results
// holds the output longer while input continues. Sync active-high rst: lexer idle, line 1.
module json_token_lexer_unit import jtl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] value_byte, [9:8] error_code, [33:10] line_number, zero pad
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last_of_run
);

  logic                  q_full, push, pop, head_valid;
  bundle_t               bundle, head;
  result_t               res;
  logic [LINE_OUT_W-1:0] line;

  jtl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_eoi   (s_tlast),
    .q_full   (q_full),
    .in_ready (s_tready),
    .push     (push),
    .bundle   (bundle)
  );

  jtl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (bundle),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  jtl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (res),
    .out_line   (line),
    .out_last   (m_tlast)
  );

  assign m_tdata = {6'b000000, line, res.err, res.value};
  assign m_tuser = res.kind;

endmodule

// ===== hdl/jtl_front.sv =====
// Front end: accepts text beats, runs the lexer state, and builds a result bundle.
// Depends on jtl_pkg.
module jtl_front import jtl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_eoi,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output bundle_t    bundle
);

  typedef enum logic [2:0] {
    M_SKIP = 3'd0,
    M_WORD = 3'd1,
    M_STR  = 3'd2,
    M_ESC  = 3'd3,
    M_HEX  = 3'd4,
    M_HALT = 3'd5
  } mode_t;

  localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;

  mode_t                 mode, mode_next;
  logic [15:0]           hex_value, hex_value_next;
  logic [1:0]            hex_cnt, hex_cnt_next;
  logic [LINE_WIDTH-1:0] line_count, line_count_next;
  logic                  accept;

  function automatic logic is_punct(input logic [7:0] c);
    return c == CH_COMMA || c == CH_COLON || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_LBRACE || c == CH_RBRACE;
  endfunction

  function automatic result_t tok(input logic [7:0] c);
    tok = '{kind: KIND_BYTE, value: c, err: ERR_INVALID};
  endfunction

  function automatic result_t mark(input kind_t k, input err_t e);
    mark = '{kind: k, value: 8'h00, err: e};
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [7:0]  c;
    logic        hex_ok;
    logic [3:0]  digit;
    logic [15:0] v;
    c               = in_byte;
    mode_next       = mode;
    hex_value_next  = hex_value;
    hex_cnt_next    = hex_cnt;
    line_count_next = line_count;
    bundle.cnt      = 2'd0;
    bundle.res      = '0;
    bundle.line     = LINE_OUT_W'(line_count);
    hex_ok          = 1'b0;
    digit           = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_ok = 1'b1;
      digit  = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      hex_ok = 1'b1;
      digit  = c[3:0] + 4'd9;
    end
    v = {hex_value[11:0], digit};

    if (in_eoi) begin
      unique case (mode)
        M_WORD, M_STR: begin
          bundle.res[0] = mark(KIND_TEND, ERR_INVALID);
          bundle.res[1] = mark(KIND_EOI, ERR_INVALID);
          bundle.cnt    = 2'd2;
        end
        M_ESC: begin
          bundle.res[0] = mark(KIND_ERR, ERR_SYNTAX);
          bundle.res[1] = mark(KIND_EOI, ERR_INVALID);
          bundle.cnt    = 2'd2;
        end
        M_HEX: begin
          bundle.res[0] = mark(KIND_ERR, ERR_EOF_ESC);
          bundle.res[1] = mark(KIND_EOI, ERR_INVALID);
          bundle.cnt    = 2'd2;
        end
        default: begin
          bundle.res[0] = mark(KIND_EOI, ERR_INVALID);
          bundle.cnt    = 2'd1;
        end
      endcase
      // rearm
      mode_next       = M_SKIP;
      hex_value_next  = 16'h0000;
      hex_cnt_next    = 2'd0;
      line_count_next = LINE_WIDTH'(1);
    end else begin
      unique case (mode)
        M_ESC: begin
          bundle.cnt = 2'd1;
          mode_next  = M_STR;
          unique case (c)
            CH_B:   bundle.res[0] = tok(CH_BS);
            CH_F:   bundle.res[0] = tok(CH_FF);
            CH_N:   bundle.res[0] = tok(CH_LF);
            CH_R:   bundle.res[0] = tok(CH_CR);
            CH_T:   bundle.res[0] = tok(CH_TAB);
            CH_QUOTE, CH_SLASH, CH_BSLASH: bundle.res[0] = tok(c);
            CH_U: begin
              bundle.cnt     = 2'd0;
              mode_next      = M_HEX;
              hex_value_next = 16'h0000;
              hex_cnt_next   = 2'd0;
            end
            default: begin
              bundle.res[0] = mark(KIND_ERR, ERR_SYNTAX);
              mode_next     = M_HALT;
            end
          endcase
        end
        M_HEX: begin
          if (!hex_ok) begin
            bundle.res[0] = mark(KIND_ERR, ERR_SYNTAX);
            bundle.cnt    = 2'd1;
            mode_next     = M_HALT;
          end else if (hex_cnt != 2'd3) begin
            hex_value_next = v;
            hex_cnt_next   = hex_cnt + 2'd1;
          end else begin
            hex_value_next = 16'h0000;
            hex_cnt_next   = 2'd0;
            mode_next      = M_STR;
            if (v == 16'h0000) begin
              bundle.res[0] = mark(KIND_ERR, ERR_INVALID);
              bundle.cnt    = 2'd1;
              mode_next     = M_HALT;
            end else if (v >= UTF_3BYTE_MIN) begin
              bundle.res[0] = tok({4'hE, v[15:12]});
              bundle.res[1] = tok({2'b10, v[11:6]});
              bundle.res[2] = tok({2'b10, v[5:0]});
              bundle.cnt    = 2'd3;
            end else if (v >= UTF_2BYTE_MIN) begin
              bundle.res[0] = tok({3'b110, v[10:6]});
              bundle.res[1] = tok({2'b10, v[5:0]});
              bundle.cnt    = 2'd2;
            end else begin
              bundle.res[0] = tok(v[7:0]);
              bundle.cnt    = 2'd1;
            end
          end
        end
        M_SKIP, M_WORD, M_STR: begin
          if (c <= CH_SPACE) begin
            if (c == CH_NUL) begin
              bundle.res[0] = mark(KIND_ERR, ERR_INVALID);
              bundle.cnt    = 2'd1;
              mode_next     = M_HALT;
            end else if (mode == M_STR) begin
              bundle.cnt = 2'd1;
              if (c == CH_LF) begin
                bundle.res[0] = mark(KIND_ERR, ERR_NEWLINE);
                mode_next     = M_HALT;
              end else if (c != CH_TAB && c != CH_SPACE) begin
                bundle.res[0] = mark(KIND_ERR, ERR_INVALID);
                mode_next     = M_HALT;
              end else begin
                bundle.res[0] = tok(c);
              end
            end else begin
              if (mode == M_WORD) begin
                bundle.res[0] = mark(KIND_TEND, ERR_INVALID);
                bundle.cnt    = 2'd1;
                mode_next     = M_SKIP;
              end
              // token end keeps the old line; count advances after
              if (c == CH_LF && line_count != LINE_MAX) begin
                line_count_next = line_count + LINE_WIDTH'(1);
              end
            end
          end else if (mode == M_SKIP) begin
            bundle.res[0] = tok(c);
            bundle.cnt    = 2'd1;
            if (c == CH_QUOTE) begin
              mode_next = M_STR;
            end else if (is_punct(c)) begin
              bundle.res[1] = mark(KIND_TEND, ERR_INVALID);
              bundle.cnt    = 2'd2;
            end else begin
              mode_next = M_WORD;
            end
          end else if (mode == M_WORD) begin
            if (c == CH_QUOTE) begin
              bundle.res[0] = mark(KIND_ERR, ERR_SYNTAX);
              bundle.cnt    = 2'd1;
              mode_next     = M_HALT;
            end else if (is_punct(c)) begin
              bundle.res[0] = mark(KIND_TEND, ERR_INVALID);
              bundle.res[1] = tok(c);
              bundle.res[2] = mark(KIND_TEND, ERR_INVALID);
              bundle.cnt    = 2'd3;
              mode_next     = M_SKIP;
            end else begin
              bundle.res[0] = tok(c);
              bundle.cnt    = 2'd1;
            end
          end else begin
            if (c == CH_QUOTE) begin
              bundle.res[0] = tok(c);
              bundle.res[1] = mark(KIND_TEND, ERR_INVALID);
              bundle.cnt    = 2'd2;
              mode_next     = M_SKIP;
            end else if (c == CH_BSLASH) begin
              mode_next = M_ESC;
            end else begin
              bundle.res[0] = tok(c);
              bundle.cnt    = 2'd1;
            end
          end
        end
        default: begin
          // halted: drop data beats
        end
      endcase
    end
  end

  assign push = accept && (bundle.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_SKIP;
      hex_value  <= 16'h0000;
      hex_cnt    <= 2'd0;
      line_count <= LINE_WIDTH'(1);
    end else if (accept) begin
      mode       <= mode_next;
      hex_value  <= hex_value_next;
      hex_cnt    <= hex_cnt_next;
      line_count <= line_count_next;
    end
  end

endmodule

// ===== hdl/jtl_queue.sv =====
// Short bundle queue between the lexer front end and the result serializer.
// Depends on jtl_pkg.
module jtl_queue import jtl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    head_valid,
  output bundle_t head
);

  bundle_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/jtl_back.sv =====
// Back end: walks the results of the queue head bundle out one beat at a time.
// Depends on jtl_pkg.
module jtl_back import jtl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  bundle_t     head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res,
  output logic [LINE_OUT_W-1:0] out_line,
  output logic        out_last
);

  logic [1:0] idx;
  logic       fire;

  assign out_valid = head_valid;
  assign out_res   = head.res[idx];
  assign out_line  = head.line;
  assign out_last  = (idx == head.cnt - 2'd1);
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      // advance within the bundle, wrap on its last beat
      idx <= out_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== dv/json_token_lexer_checker.sv =====
`timescale 1ns / 100ps
// Checker for json_token_lexer_unit: models the lexer on every input beat
// and compares each output beat against the oldest predicted token beat.
// Depends on jtl_pkg for result kinds, error codes and character codes.
module json_token_lexer_checker import jtl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_input
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [7:0] value_byte, [9:8] error_code, [33:10] line_number
  input  logic [1:0]  m_tuser,   // [1:0] kind
  input  logic        m_tlast,   // last_of_run
  output int          mismatch_count,
  output int          pending_count
);

  typedef enum logic [2:0] {
    LX_SKIP = 3'd0,
    LX_WORD = 3'd1,
    LX_STR  = 3'd2,
    LX_ESC  = 3'd3,
    LX_HEX  = 3'd4,
    LX_HALT = 3'd5
  } lex_mode_t;

  typedef struct {
    kind_t                 kind;
    logic [7:0]            value;
    err_t                  err;
    logic [LINE_OUT_W-1:0] line;
    logic                  last;
  } token_beat_t;

  token_beat_t           expected_tokens[$];
  lex_mode_t             lex_mode;
  logic [15:0]           hex_acc;
  logic [1:0]            hex_cnt;
  logic [LINE_WIDTH-1:0] line_cnt;
  int                    mismatches = 0;
  int                    queued = 0;

  assign mismatch_count = mismatches;
  assign pending_count  = queued;

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic rearm_lexer();
    lex_mode = LX_SKIP;
    hex_acc  = '0;
    hex_cnt  = '0;
    line_cnt = LINE_WIDTH'(1);
  endtask

  task automatic emit_beat(kind_t k, logic [7:0] v, err_t e);
    token_beat_t b;
    b.kind  = k;
    b.value = v;
    b.err   = e;
    b.line  = LINE_OUT_W'(line_cnt);
    b.last  = 1'b0;
    expected_tokens.insert(expected_tokens.size(), b);
  endtask

  task automatic lex_error(err_t e);
    emit_beat(KIND_ERR, 8'h00, e);
    lex_mode = LX_HALT;
  endtask

  function automatic bit is_punct(logic [7:0] c);
    return c == CH_COMMA || c == CH_COLON || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_LBRACE || c == CH_RBRACE;
  endfunction

  // -1 for a byte that is no hex digit
  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9")
      return int'(c[3:0]);
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
      return int'(c[3:0]) + 9;
    return -1;
  endfunction

  task automatic lex_hex_digit(logic [7:0] c);
    int          d;
    logic [15:0] v;
    d = hex_nibble(c);
    if (d < 0) begin
      lex_error(ERR_SYNTAX);
    end else begin
      v = {hex_acc[11:0], 4'(d)};
      if (hex_cnt != 2'd3) begin
        hex_acc = v;
        hex_cnt++;
      end else begin
        hex_acc = '0;
        hex_cnt = '0;
        if (v == 16'h0000) begin
          lex_error(ERR_INVALID);
        end else begin
          // surrogates get no special treatment: plain three-byte form
          if (v >= UTF_3BYTE_MIN) begin
            emit_beat(KIND_BYTE, {4'b1110, v[15:12]}, ERR_INVALID);
            emit_beat(KIND_BYTE, {2'b10, v[11:6]}, ERR_INVALID);
          end else if (v >= UTF_2BYTE_MIN) begin
            emit_beat(KIND_BYTE, {3'b110, v[10:6]}, ERR_INVALID);
          end
          if (v >= UTF_2BYTE_MIN)
            emit_beat(KIND_BYTE, {2'b10, v[5:0]}, ERR_INVALID);
          else
            emit_beat(KIND_BYTE, v[7:0], ERR_INVALID);
          lex_mode = LX_STR;
        end
      end
    end
  endtask

  task automatic lex_escape(logic [7:0] c);
    logic [7:0] ch;
    bit         keep;
    ch   = c;
    keep = 1'b1;
    case (c)
      CH_B: ch = CH_BS;
      CH_F: ch = CH_FF;
      CH_N: ch = CH_LF;
      CH_R: ch = CH_CR;
      CH_T: ch = CH_TAB;
      CH_QUOTE, CH_SLASH, CH_BSLASH: ch = c;
      CH_U: begin
        keep     = 1'b0;
        lex_mode = LX_HEX;
        hex_acc  = '0;
        hex_cnt  = '0;
      end
      default: begin
        keep = 1'b0;
        lex_error(ERR_SYNTAX);
      end
    endcase
    if (keep) begin
      emit_beat(KIND_BYTE, ch, ERR_INVALID);
      lex_mode = LX_STR;
    end
  endtask

  task automatic lex_text(logic [7:0] c);
    if (c <= CH_SPACE) begin
      if (c == CH_NUL) begin
        lex_error(ERR_INVALID);
      end else if (lex_mode == LX_STR) begin
        if (c == CH_LF)
          lex_error(ERR_NEWLINE);
        else if (c == CH_TAB || c == CH_SPACE)
          emit_beat(KIND_BYTE, c, ERR_INVALID);
        else
          lex_error(ERR_INVALID);
      end else begin
        // close the word on the old line, then advance the line
        if (lex_mode == LX_WORD) begin
          emit_beat(KIND_TEND, 8'h00, ERR_INVALID);
          lex_mode = LX_SKIP;
        end
        if (c == CH_LF && line_cnt != '1)
          line_cnt++;
      end
    end else if (lex_mode == LX_SKIP) begin
      emit_beat(KIND_BYTE, c, ERR_INVALID);
      if (c == CH_QUOTE)
        lex_mode = LX_STR;
      else if (is_punct(c))
        emit_beat(KIND_TEND, 8'h00, ERR_INVALID);
      else
        lex_mode = LX_WORD;
    end else if (lex_mode == LX_WORD) begin
      if (c == CH_QUOTE) begin
        lex_error(ERR_SYNTAX);
      end else if (is_punct(c)) begin
        emit_beat(KIND_TEND, 8'h00, ERR_INVALID);
        emit_beat(KIND_BYTE, c, ERR_INVALID);
        emit_beat(KIND_TEND, 8'h00, ERR_INVALID);
        lex_mode = LX_SKIP;
      end else begin
        emit_beat(KIND_BYTE, c, ERR_INVALID);
      end
    end else begin
      if (c == CH_QUOTE) begin
        emit_beat(KIND_BYTE, c, ERR_INVALID);
        emit_beat(KIND_TEND, 8'h00, ERR_INVALID);
        lex_mode = LX_SKIP;
      end else if (c == CH_BSLASH) begin
        lex_mode = LX_ESC;
      end else begin
        emit_beat(KIND_BYTE, c, ERR_INVALID);
      end
    end
  endtask

  task automatic lex_end_of_input();
    case (lex_mode)
      LX_WORD, LX_STR: emit_beat(KIND_TEND, 8'h00, ERR_INVALID);
      LX_ESC:          emit_beat(KIND_ERR, 8'h00, ERR_SYNTAX);
      LX_HEX:          emit_beat(KIND_ERR, 8'h00, ERR_EOF_ESC);
      default: ;
    endcase
    emit_beat(KIND_EOI, 8'h00, ERR_INVALID);
    rearm_lexer();
  endtask

  task automatic lex_input(logic [7:0] c, logic eoi);
    int          prior_size;
    int          tail_idx;
    token_beat_t tail;
    prior_size = expected_tokens.size();
    if (eoi)
      lex_end_of_input();
    else if (lex_mode == LX_ESC)
      lex_escape(c);
    else if (lex_mode == LX_HEX)
      lex_hex_digit(c);
    else if (lex_mode <= LX_STR)
      lex_text(c);
    // mark the final beat of this input's run
    if (expected_tokens.size() > prior_size) begin
      tail_idx                  = expected_tokens.size() - 1;
      tail                      = expected_tokens[tail_idx];
      tail.last                 = 1'b1;
      expected_tokens[tail_idx] = tail;
    end
  endtask

  task automatic check_beat();
    token_beat_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("beat with nothing expected: kind %0d value 0x%02h",
                                m_tuser, m_tdata[7:0]));
    end else begin
      want = expected_tokens.pop_front();
      if (m_tuser !== want.kind)
        report_mismatch($sformatf("kind got %0d want %0d", m_tuser, want.kind));
      if (m_tdata[7:0] !== want.value)
        report_mismatch($sformatf("value_byte got 0x%02h want 0x%02h", m_tdata[7:0],
                                  want.value));
      if (m_tdata[9:8] !== want.err)
        report_mismatch($sformatf("error_code got %0d want %0d", m_tdata[9:8], want.err));
      if (m_tdata[10 +: LINE_OUT_W] !== want.line)
        report_mismatch($sformatf("line_number got %0d want %0d", m_tdata[10 +: LINE_OUT_W],
                                  want.line));
      if (m_tlast !== want.last)
        report_mismatch($sformatf("last_of_run got %b want %b", m_tlast, want.last));
      if (m_tdata[39:10+LINE_OUT_W] !== '0)
        report_mismatch($sformatf("pad bits got 0x%0h", m_tdata[39:10+LINE_OUT_W]));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rearm_lexer();
      expected_tokens.delete();
    end else begin
      // output first: a beat accepted now can only stem from an earlier input
      if (m_tvalid && m_tready)
        check_beat();
      if (s_tvalid && s_tready)
        lex_input(s_tdata, s_tlast);
    end
    queued <= expected_tokens.size();
  end

endmodule

// ===== dv/tb_json_token_lexer_unit.sv =====
`timescale 1ns / 100ps
// Top of the json_token_lexer_unit testbench: clock, reset, text stimulus
// and output backpressure; the checker does prediction and comparison.
// Depends on jtl_pkg, json_token_lexer_unit and json_token_lexer_checker.
module tb_json_token_lexer_unit;
  import jtl_pkg::*;

  localparam int DIRECTED_ITEMS = 27;
  localparam int RANDOM_ITEMS   = 143;
  localparam int QUIET_TAIL     = 40;
  localparam int CYCLE_LIMIT    = 300000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int mismatch_count;
  int pending_count;
  int items_sent = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;

  logic [7:0] esc_letters[8] = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_QUOTE, CH_SLASH, CH_BSLASH};
  logic [7:0] punct_chars[6] = '{CH_COMMA, CH_COLON, CH_LBRACK, CH_RBRACK, CH_LBRACE,
                                 CH_RBRACE};

  json_token_lexer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  json_token_lexer_checker token_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_json_token_lexer_unit: FAIL");
      $finish;
    end
  end

  // Output backpressure: ready runs broken by stall bursts, none in the tail
  initial begin
    m_tready <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 10)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic eoi);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= eoi ? 8'($urandom) : b;
    s_tlast  <= eoi;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  task automatic send_eoi();
    send_item(8'h00, 1'b1);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10)
      return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
  endfunction

  task automatic send_hex_digits(logic [15:0] v, int count);
    for (int i = 3; i > 3 - count; i--)
      send_byte(hex_char(v[4*i +: 4]));
  endtask

  function automatic logic [15:0] pick_code_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return 16'h0000;
    if (r < 35)
      return 16'($urandom_range(16'h0001, 16'h007F));
    if (r < 65)
      return 16'($urandom_range(16'h0080, 16'h07FF));
    return 16'($urandom_range(16'h0800, 16'hFFFF));
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 9) < 7)
        c = 8'($urandom_range(8'h21, 8'h7E));
      else
        c = 8'($urandom_range(8'h21, 8'hFF));
    end while (c == CH_QUOTE);
    return c;
  endfunction

  // Mostly printable; now and then any byte, control bytes and zero included
  function automatic logic [7:0] string_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 99) < 85)
        c = 8'($urandom_range(8'h20, 8'h7E));
      else
        c = 8'($urandom);
    end while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  task automatic send_whitespace();
    case ($urandom_range(0, 4))
      0: send_byte(CH_SPACE);
      1: send_byte(CH_TAB);
      2: send_byte(CH_LF);
      3: send_byte(CH_CR);
      default: send_byte(8'($urandom_range(8'h01, 8'h20)));
    endcase
  endtask

  task automatic send_word();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) send_byte(word_char());
    case ($urandom_range(0, 3))
      0: send_whitespace();
      1: send_byte(punct_chars[$urandom_range(0, 5)]);
      default: ;
    endcase
  endtask

  task automatic send_string();
    int n;
    int r;
    int k;
    n = $urandom_range(0, 5);
    send_byte(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_byte(string_char());
      end else if (r < 65) begin
        send_byte(CH_BSLASH);
        send_byte(esc_letters[$urandom_range(0, 7)]);
      end else if (r < 85) begin
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        send_hex_digits(pick_code_point(), 4);
      end else if (r < 89) begin
        send_byte(CH_BSLASH);
        send_byte(8'($urandom));
      end else if (r < 93) begin
        // hex escape of up to three digits, then an arbitrary byte
        k = $urandom_range(0, 3);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        send_hex_digits(16'($urandom), k);
        send_byte(8'($urandom));
      end else if (r < 96) begin
        send_byte(CH_BSLASH);
        send_eoi();
        return;
      end else begin
        k = $urandom_range(0, 3);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        send_hex_digits(16'($urandom), k);
        send_eoi();
        return;
      end
    end
    if ($urandom_range(0, 9) != 0)
      send_byte(CH_QUOTE);
  endtask

  initial begin
    int r;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tlast  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // punctuation, word closed by punctuation, word closed by newline
    send_byte(CH_LBRACK);
    send_byte("t");
    send_byte(CH_COMMA);
    send_byte("7");
    send_byte(CH_LF);
    // three-byte escape, tab kept in a string, end of input after backslash
    send_byte(CH_QUOTE);
    send_byte(CH_BSLASH);
    send_byte(CH_U);
    send_byte("F");
    send_byte("F");
    send_byte("f");
    send_byte("f");
    send_byte(CH_TAB);
    send_byte(CH_BSLASH);
    send_eoi();
    // quote inside a word halts; halted bytes give nothing
    send_byte(8'hFF);
    send_byte(CH_QUOTE);
    send_byte(CH_NUL);
    send_eoi();
    // zero byte and newline inside strings
    send_byte(CH_QUOTE);
    send_byte(CH_NUL);
    send_eoi();
    send_byte(CH_QUOTE);
    send_byte(CH_LF);
    send_eoi();
    // partial word closed by end of input
    send_byte("x");
    send_eoi();

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      quiet = items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS - QUIET_TAIL;
      r = $urandom_range(0, 99);
      if (r < 12)
        send_whitespace();
      else if (r < 27)
        send_byte(punct_chars[$urandom_range(0, 5)]);
      else if (r < 47)
        send_word();
      else if (r < 77)
        send_string();
      else if (r < 85)
        send_byte(8'($urandom));
      else
        send_eoi();
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_json_token_lexer_unit: PASS");
    else
      $display("tb_json_token_lexer_unit: FAIL");
    $finish;
  end

endmodule
